// ===== rtl/spinor_pkg.sv =====
package spinor_pkg;

  // Request selectors carried in req_type. Code 7 is unused and ignored.
  typedef enum logic [2:0] {
    REQ_WR_START = 3'd0,
    REQ_WR_BYTE  = 3'd1,
    REQ_RD_START = 3'd2,
    REQ_RD_BYTE  = 3'd3,
    REQ_SECTOR   = 3'd4,
    REQ_BULK     = 3'd5,
    REQ_RD_ID    = 3'd6
  } req_t;

  localparam logic [7:0] CMD_PROGRAM   = 8'h02;
  localparam logic [7:0] CMD_WR_ENABLE = 8'h06;
  localparam logic [7:0] CMD_READ_DATA = 8'h03;
  localparam logic [7:0] CMD_STATUS    = 8'h05;
  localparam logic [7:0] CMD_IDENT     = 8'h9F;
  localparam logic [7:0] CMD_SECTOR    = 8'h20;
  localparam logic [7:0] CMD_CHIP      = 8'hC7;
  localparam logic [7:0] FILL_BYTE     = 8'hA5;

  localparam int ADDR_W    = 24;
  localparam int MAX_SLOTS = 7;
  localparam int CNT_W     = 3;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       frame_end;
    logic       poll_status;
    logic       capture;
    logic       last_of_run;
  } out_item_t;

  // One byte of a planned run, without the end-of-run mark.
  typedef struct packed {
    logic [7:0] bus_byte;
    logic       frame_end;
    logic       poll_status;
    logic       capture;
  } slot_t;

  typedef struct packed {
    logic [CNT_W-1:0]            count;
    slot_t [MAX_SLOTS-1:0]       slots;
  } plan_t;

  // Status of the page-offset unit.
  typedef struct packed {
    logic busy;
    logic done;
  } pg_stat_t;

  function automatic slot_t mk_slot(input logic [7:0] b, input logic fe,
                                    input logic poll, input logic cap);
    slot_t s;
    s.bus_byte    = b;
    s.frame_end   = fe;
    s.poll_status = poll;
    s.capture     = cap;
    return s;
  endfunction

endpackage

// ===== rtl/spi_nor_flash_command_framer.sv =====
// SPI NOR command framer. Each request item on the in_ channel is turned into
// the run of bytes to shift out on the out_ channel, with chip-select release
// marks, a status-poll flag, a capture flag for bytes whose returned value is
// data, and last_of_run on the final byte caused by that request.
// An item is taken when in_valid is high and in_stall is low; a result item
// moves when out_valid is high and out_stall is low.
// A taken request's plan is registered in the run buffer, and its bytes then
// move one at a time to the output register. Bytes of a run leave one per
// cycle while the receiver does not stall; a request frames 1 to 7 bytes, and
// the next request is taken in the same cycle as the last byte of the current
// run goes to the output register. Requests that frame nothing are consumed
// without output, except write start, which holds in_stall while the page
// offset of the new address is computed by a two-stage reciprocal multiply.
// While the receiver stalls, the output holds its byte and the byte run
// pauses; in_stall rises once the run buffer cannot take a new plan.
// Synchronous reset clears the write pointer, the open program and read frame
// flags and all valid state; no item is pending after reset.
module spi_nor_flash_command_framer #(
  parameter int PAGE_BYTES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  spinor_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spinor_pkg::out_item_t out_item
);

  logic              plan_free, plan_load;
  spinor_pkg::plan_t plan;

  spinor_dec #(.PAGE_BYTES(PAGE_BYTES)) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .plan_free (plan_free),
    .in_stall  (in_stall),
    .plan_load (plan_load),
    .plan      (plan)
  );

  spinor_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .plan_load (plan_load),
    .plan      (plan),
    .plan_free (plan_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/spinor_pgmod.sv =====
// Computes address % PAGE_BYTES in two stages: a reciprocal multiply for the
// quotient, then a multiply and subtract for the remainder.
module spinor_pgmod #(
  parameter int PAGE_BYTES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [spinor_pkg::ADDR_W-1:0]       addr,
  output spinor_pkg::pg_stat_t                stat,
  output logic [$clog2(PAGE_BYTES)-1:0]       rem
);

  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int AW      = spinor_pkg::ADDR_W;
  localparam int SHIFT   = AW + OFF_W;
  localparam int MAG_W   = AW + 1;
  localparam int PROD_W  = AW + MAG_W;
  // With 2^SHIFT >= 2^AW * PAGE_BYTES the rounded-up reciprocal gives the
  // exact quotient for every address.
  localparam longint unsigned MAGIC_L =
    ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [MAG_W-1:0] MAGIC   = MAG_W'(MAGIC_L);
  localparam logic [AW-1:0]    PAGE_AW = AW'(PAGE_BYTES);

  logic           s1_v_r, s2_v_r;
  logic [AW-1:0]  a1_r, a2_r, q2_r;
  logic [PROD_W-1:0] prod;
  logic [AW-1:0]  diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= start;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a1_r <= addr;
    end
    a2_r <= a1_r;
    q2_r <= AW'(prod >> SHIFT);
  end

  always_comb begin
    prod      = PROD_W'(a1_r) * PROD_W'(MAGIC);
    diff      = a2_r - AW'(q2_r * PAGE_AW);
    rem       = diff[OFF_W-1:0];
    stat.busy = s1_v_r || s2_v_r;
    stat.done = s2_v_r;
  end

endmodule

// ===== rtl/spinor_dec.sv =====
module spinor_dec #(
  parameter int PAGE_BYTES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  spinor_pkg::in_item_t in_item,
  input  logic                 plan_free,
  output logic                 in_stall,
  output logic                 plan_load,
  output spinor_pkg::plan_t    plan
);

  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int AW    = spinor_pkg::ADDR_W;
  localparam logic [OFF_W:0] PAGE_LIM = (OFF_W + 1)'(PAGE_BYTES);

  logic [AW-1:0]    wp_r, wp_nxt, wp_inc;
  logic [OFF_W-1:0] off_r, off_nxt, off_step, pg_rem;
  logic [OFF_W:0]   off_inc;
  logic             chunk_open_r, chunk_open_nxt;
  logic             read_open_r, read_open_nxt;
  logic             accept, blocked, off_wrap, close, pg_start;
  spinor_pkg::req_t     req;
  spinor_pkg::pg_stat_t pg_stat;

  spinor_pgmod #(.PAGE_BYTES(PAGE_BYTES)) u_pgmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pg_start),
    .addr  (in_item.address),
    .stat  (pg_stat),
    .rem   (pg_rem)
  );

  assign in_stall = !plan_free || pg_stat.busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    req      = spinor_pkg::req_t'(in_item.req_type);
    blocked  = (chunk_open_r && req != spinor_pkg::REQ_WR_BYTE) ||
               (read_open_r  && req != spinor_pkg::REQ_RD_BYTE);
    wp_inc   = wp_r + AW'(1);
    off_inc  = {1'b0, off_r} + (OFF_W + 1)'(1);
    // Address zero after a wrap also counts as a page boundary.
    off_wrap = (off_inc == PAGE_LIM) || (wp_inc == '0);
    off_step = off_wrap ? '0 : off_inc[OFF_W-1:0];
    close    = in_item.last || off_wrap;

    plan           = '0;
    pg_start       = 1'b0;
    wp_nxt         = wp_r;
    off_nxt        = off_r;
    chunk_open_nxt = chunk_open_r;
    read_open_nxt  = read_open_r;

    if (!blocked) begin
      unique case (req)
        spinor_pkg::REQ_WR_START: begin
          pg_start = accept;
          if (accept) begin
            wp_nxt = in_item.address;
          end
        end
        spinor_pkg::REQ_WR_BYTE: begin
          if (!chunk_open_r) begin
            plan.slots[0] = spinor_pkg::mk_slot(spinor_pkg::CMD_WR_ENABLE, 1'b1, 1'b0, 1'b0);
            plan.slots[1] = spinor_pkg::mk_slot(spinor_pkg::CMD_PROGRAM, 1'b0, 1'b0, 1'b0);
            plan.slots[2] = spinor_pkg::mk_slot(wp_r[23:16], 1'b0, 1'b0, 1'b0);
            plan.slots[3] = spinor_pkg::mk_slot(wp_r[15:8], 1'b0, 1'b0, 1'b0);
            plan.slots[4] = spinor_pkg::mk_slot(wp_r[7:0], 1'b0, 1'b0, 1'b0);
            plan.slots[5] = spinor_pkg::mk_slot(in_item.data, close, 1'b0, 1'b0);
            plan.slots[6] = spinor_pkg::mk_slot(spinor_pkg::CMD_STATUS, 1'b0, close, 1'b0);
            plan.count    = close ? 3'd7 : 3'd6;
          end else begin
            plan.slots[0] = spinor_pkg::mk_slot(in_item.data, close, 1'b0, 1'b0);
            plan.slots[1] = spinor_pkg::mk_slot(spinor_pkg::CMD_STATUS, 1'b0, close, 1'b0);
            plan.count    = close ? 3'd2 : 3'd1;
          end
          if (accept) begin
            wp_nxt         = wp_inc;
            off_nxt        = off_step;
            chunk_open_nxt = !close;
          end
        end
        spinor_pkg::REQ_RD_START: begin
          plan.slots[0] = spinor_pkg::mk_slot(spinor_pkg::CMD_READ_DATA, 1'b0, 1'b0, 1'b0);
          plan.slots[1] = spinor_pkg::mk_slot(in_item.address[23:16], 1'b0, 1'b0, 1'b0);
          plan.slots[2] = spinor_pkg::mk_slot(in_item.address[15:8], 1'b0, 1'b0, 1'b0);
          plan.slots[3] = spinor_pkg::mk_slot(in_item.address[7:0], 1'b0, 1'b0, 1'b0);
          plan.count    = 3'd4;
          if (accept) begin
            read_open_nxt = 1'b1;
          end
        end
        spinor_pkg::REQ_RD_BYTE: begin
          if (read_open_r) begin
            plan.slots[0] = spinor_pkg::mk_slot(spinor_pkg::FILL_BYTE, in_item.last,
                                                1'b0, 1'b1);
            plan.count    = 3'd1;
            if (accept && in_item.last) begin
              read_open_nxt = 1'b0;
            end
          end
        end
        spinor_pkg::REQ_SECTOR: begin
          plan.slots[0] = spinor_pkg::mk_slot(spinor_pkg::CMD_WR_ENABLE, 1'b1, 1'b0, 1'b0);
          plan.slots[1] = spinor_pkg::mk_slot(spinor_pkg::CMD_SECTOR, 1'b0, 1'b0, 1'b0);
          plan.slots[2] = spinor_pkg::mk_slot(in_item.address[23:16], 1'b0, 1'b0, 1'b0);
          plan.slots[3] = spinor_pkg::mk_slot(in_item.address[15:8], 1'b0, 1'b0, 1'b0);
          plan.slots[4] = spinor_pkg::mk_slot(in_item.address[7:0], 1'b1, 1'b0, 1'b0);
          plan.slots[5] = spinor_pkg::mk_slot(spinor_pkg::CMD_STATUS, 1'b0, 1'b1, 1'b0);
          plan.count    = 3'd6;
        end
        spinor_pkg::REQ_BULK: begin
          plan.slots[0] = spinor_pkg::mk_slot(spinor_pkg::CMD_WR_ENABLE, 1'b1, 1'b0, 1'b0);
          plan.slots[1] = spinor_pkg::mk_slot(spinor_pkg::CMD_CHIP, 1'b1, 1'b0, 1'b0);
          plan.slots[2] = spinor_pkg::mk_slot(spinor_pkg::CMD_STATUS, 1'b0, 1'b1, 1'b0);
          plan.count    = 3'd3;
        end
        spinor_pkg::REQ_RD_ID: begin
          plan.slots[0] = spinor_pkg::mk_slot(spinor_pkg::CMD_IDENT, 1'b0, 1'b0, 1'b0);
          plan.slots[1] = spinor_pkg::mk_slot(spinor_pkg::FILL_BYTE, 1'b0, 1'b0, 1'b1);
          plan.slots[2] = spinor_pkg::mk_slot(spinor_pkg::FILL_BYTE, 1'b0, 1'b0, 1'b1);
          plan.slots[3] = spinor_pkg::mk_slot(spinor_pkg::FILL_BYTE, 1'b1, 1'b0, 1'b1);
          plan.count    = 3'd4;
        end
        default: begin
          plan = '0;
        end
      endcase
    end

    // The input is held off while the offset unit runs, so no item competes.
    if (pg_stat.done) begin
      off_nxt = pg_rem;
    end

    plan_load = accept && (plan.count != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      off_r        <= '0;
      chunk_open_r <= 1'b0;
      read_open_r  <= 1'b0;
    end else begin
      wp_r         <= wp_nxt;
      off_r        <= off_nxt;
      chunk_open_r <= chunk_open_nxt;
      read_open_r  <= read_open_nxt;
    end
  end

endmodule

// ===== rtl/spinor_emit.sv =====
module spinor_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  plan_load,
  input  spinor_pkg::plan_t     plan,
  output logic                  plan_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spinor_pkg::out_item_t out_item
);

  localparam int CW = spinor_pkg::CNT_W;

  logic                  plan_v_r, plan_v_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  spinor_pkg::plan_t     plan_r;
  spinor_pkg::out_item_t out_r;
  spinor_pkg::slot_t     cur;
  logic                  adv, emit_now, last_slot;

  always_comb begin
    adv       = !out_v_r || !out_stall;
    emit_now  = plan_v_r && adv;
    last_slot = idx_r == plan_r.count - CW'(1);
    plan_free = !plan_v_r || (adv && last_slot);
    cur       = plan_r.slots[idx_r];

    plan_v_nxt = plan_v_r;
    out_v_nxt  = out_v_r;
    idx_nxt    = idx_r;
    if (emit_now) begin
      out_v_nxt = 1'b1;
      idx_nxt   = last_slot ? '0 : idx_r + CW'(1);
      if (last_slot) begin
        plan_v_nxt = 1'b0;
      end
    end else if (adv) begin
      out_v_nxt = 1'b0;
    end
    if (plan_load) begin
      plan_v_nxt = 1'b1;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      plan_v_r <= plan_v_nxt;
      out_v_r  <= out_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (plan_load) begin
      plan_r <= plan;
    end
    if (emit_now) begin
      out_r.bus_byte    <= cur.bus_byte;
      out_r.frame_end   <= cur.frame_end;
      out_r.poll_status <= cur.poll_status;
      out_r.capture     <= cur.capture;
      out_r.last_of_run <= last_slot;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/spinor_chk.sv =====
module spinor_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input spinor_pkg::in_item_t  in_item,
  input logic                  out_valid,
  input logic                  out_stall,
  input spinor_pkg::out_item_t out_item
);

  // A stalled request must stay offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("request changed while stalled");

  // A stalled result must stay put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // The status opcode always ends its run and leaves select to the engine.
  a_poll_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.poll_status |->
      out_item.bus_byte == spinor_pkg::CMD_STATUS && out_item.last_of_run &&
      !out_item.frame_end)
    else $error("status poll byte malformed");

  // Only dummy bytes are marked for capture.
  a_capture_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.capture |->
      out_item.bus_byte == spinor_pkg::FILL_BYTE && !out_item.poll_status)
    else $error("capture on a non-dummy byte");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spi_nor_flash_command_framer spinor_chk u_chk (.*);
